### hw/rtl/gbet_pkg.sv
// ----------------------------------------------------------------------------
// Grid button event translator package
// Shared types and constants for the button grid event translator.
// ----------------------------------------------------------------------------
package gbet_pkg;

  localparam int unsigned NUM_BUTTONS   = 32;
  localparam int unsigned BTN_W         = $clog2(NUM_BUTTONS);
  localparam int unsigned STAMP_W       = 32;
  localparam int unsigned TIMING_W      = 8;
  localparam int unsigned THR_W         = 16;
  localparam int unsigned PROD_W        = 13;
  localparam logic [THR_W-1:0] HOLD_THR_RESET = 16'd500;

  typedef enum logic [1:0] {
    KIND_EXIT   = 2'd0,
    KIND_ENTER  = 2'd1,
    KIND_ADJUST = 2'd2,
    KIND_TOGGLE = 2'd3
  } kind_t;

  localparam logic signed [1:0] DELTA_NONE = 2'sb00;
  localparam logic signed [1:0] DELTA_UP   = 2'sb01;
  localparam logic signed [1:0] DELTA_DOWN = 2'sb11;

  localparam logic [2:0] TRACK_NONE = 3'd4;

endpackage

### hw/rtl/gbet_in_if.sv
// ----------------------------------------------------------------------------
// Grid button snapshot channel
// Valid/ready channel that carries one button grid snapshot per word.
// ----------------------------------------------------------------------------
interface gbet_in_if;
  import gbet_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [31:0]          button_states;
  logic                 lock_active;
  logic [BTN_W-1:0]     lock_button;
  logic [TIMING_W-1:0]  timing_bucket;
  logic [STAMP_W-1:0]   stamp_in;

  modport source (output valid, output button_states, output lock_active,
                  output lock_button, output timing_bucket, output stamp_in,
                  input ready);
  modport sink   (input valid, input button_states, input lock_active,
                  input lock_button, input timing_bucket, input stamp_in,
                  output ready);
endinterface

### hw/rtl/gbet_out_if.sv
// ----------------------------------------------------------------------------
// Grid button event channel
// Valid/ready channel that carries one control event per word.
// ----------------------------------------------------------------------------
interface gbet_out_if;
  import gbet_pkg::*;

  logic                valid;
  logic                ready;
  kind_t               kind;
  logic [2:0]          track;
  logic [2:0]          step;
  logic [2:0]          param_type;
  logic signed [1:0]   delta;
  logic [STAMP_W-1:0]  stamp_out;
  logic                last;

  modport source (output valid, output kind, output track, output step,
                  output param_type, output delta, output stamp_out,
                  output last, input ready);
  modport sink   (input valid, input kind, input track, input step,
                  input param_type, input delta, input stamp_out,
                  input last, output ready);
endinterface

### hw/rtl/grid_button_event_translator.sv
// ----------------------------------------------------------------------------
// Grid button event translator
// Turns 4 by 8 button grid snapshots into lock, adjust and toggle events.
// ----------------------------------------------------------------------------
// The in_ch channel takes one snapshot word at a time; in_ch.ready is high
// only while the block is idle. Each accepted snapshot is compared with the
// previous mask and lock flag, and gives zero, one or up to 32 event words on
// out_ch, the final one marked by last. A lock exit word goes through the scan
// state and then the output register. Entry, adjust and toggle words come from
// a single-bit scanner that shifts the change or release mask down one bit per
// cycle, and one snapshot occupies the block until its scan ends.
// A snapshot that fires no rule leaves the block idle.
// The event word sits in an output register; while out_ch.ready is low the
// scanner holds at the pending bit and resumes when the register drains.
// cfg_we writes hold_threshold_ms from cfg_wdata; write it only while idle.
// Reset clears the stored mask and lock flag, sets the threshold to 500 ms
// and empties the output register.
// ----------------------------------------------------------------------------
module grid_button_event_translator (
  input  logic                        clk,
  input  logic                        rst_n,
  gbet_in_if.sink                     in_ch,
  gbet_out_if.source                  out_ch,
  input  logic                        cfg_we,
  input  logic [gbet_pkg::THR_W-1:0]  cfg_wdata
);
  import gbet_pkg::*;

  typedef enum logic {ST_IDLE, ST_SCAN} state_t;

  state_t                  state_r, state_nxt;
  logic [THR_W-1:0]        thr_r;
  logic [31:0]             prev_btn_r, prev_btn_nxt;
  logic                    prev_lock_r, prev_lock_nxt;
  kind_t                   mode_r, mode_nxt;
  logic [31:0]             mask_r, mask_nxt;
  logic [BTN_W-1:0]        idx_r, idx_nxt;
  logic [STAMP_W-1:0]      stamp_r, stamp_nxt;

  logic                    out_valid_r, out_valid_nxt;
  kind_t                   out_kind_r, out_kind_nxt;
  logic [2:0]              out_track_r, out_track_nxt;
  logic [2:0]              out_step_r, out_step_nxt;
  logic [2:0]              out_ptype_r, out_ptype_nxt;
  logic signed [1:0]       out_delta_r, out_delta_nxt;
  logic [STAMP_W-1:0]      out_stamp_r, out_stamp_nxt;
  logic                    out_last_r, out_last_nxt;

  logic [31:0]             changed, pressed, released, lbit;
  logic [PROD_W-1:0]       hold_ms;
  logic                    out_free;
  logic                    rule_exit, rule_enter, rule_adjust, rule_toggle;

  assign in_ch.ready       = (state_r == ST_IDLE);
  assign out_ch.valid      = out_valid_r;
  assign out_ch.kind       = out_kind_r;
  assign out_ch.track      = out_track_r;
  assign out_ch.step       = out_step_r;
  assign out_ch.param_type = out_ptype_r;
  assign out_ch.delta      = out_delta_r;
  assign out_ch.stamp_out  = out_stamp_r;
  assign out_ch.last       = out_last_r;

  always_comb begin
    changed  = in_ch.button_states ^ prev_btn_r;
    pressed  = changed & in_ch.button_states;
    released = changed & prev_btn_r;
    lbit     = 32'd1 << in_ch.lock_button;
    hold_ms  = {1'b0, in_ch.timing_bucket, 4'b0000} + {3'b000, in_ch.timing_bucket, 2'b00};

    rule_exit   = in_ch.lock_active && prev_lock_r &&
                  ((prev_btn_r & lbit) != 32'd0) && ((in_ch.button_states & lbit) == 32'd0);
    rule_enter  = in_ch.lock_active && !prev_lock_r;
    rule_adjust = in_ch.lock_active && ((pressed & ~lbit) != 32'd0);
    rule_toggle = !in_ch.lock_active && (released != 32'd0) &&
                  ({{(THR_W-PROD_W){1'b0}}, hold_ms} < thr_r);

    out_free = !out_valid_r || out_ch.ready;

    state_nxt     = state_r;
    prev_btn_nxt  = prev_btn_r;
    prev_lock_nxt = prev_lock_r;
    mode_nxt      = mode_r;
    mask_nxt      = mask_r;
    idx_nxt       = idx_r;
    stamp_nxt     = stamp_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    out_kind_nxt  = out_kind_r;
    out_track_nxt = out_track_r;
    out_step_nxt  = out_step_r;
    out_ptype_nxt = out_ptype_r;
    out_delta_nxt = out_delta_r;
    out_stamp_nxt = out_stamp_r;
    out_last_nxt  = out_last_r;

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          prev_btn_nxt  = in_ch.button_states;
          prev_lock_nxt = in_ch.lock_active;
          stamp_nxt     = in_ch.stamp_in;
          idx_nxt       = '0;
          if (rule_exit) begin
            mode_nxt  = KIND_EXIT;
            state_nxt = ST_SCAN;
          end else if (rule_enter) begin
            mode_nxt  = KIND_ENTER;
            mask_nxt  = changed;
            state_nxt = ST_SCAN;
          end else if (rule_adjust) begin
            mode_nxt  = KIND_ADJUST;
            mask_nxt  = changed;
            state_nxt = ST_SCAN;
          end else if (rule_toggle) begin
            mode_nxt  = KIND_TOGGLE;
            mask_nxt  = released;
            state_nxt = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        out_kind_nxt  = out_free ? mode_r : out_kind_r;
        out_stamp_nxt = out_free ? stamp_r : out_stamp_r;
        case (mode_r)
          KIND_EXIT: begin
            if (out_free) begin
              out_valid_nxt = 1'b1;
              out_track_nxt = 3'd0;
              out_step_nxt  = 3'd0;
              out_ptype_nxt = 3'd0;
              out_delta_nxt = DELTA_NONE;
              out_last_nxt  = 1'b1;
              state_nxt     = ST_IDLE;
            end
          end
          KIND_ENTER: begin
            if (mask_r == 32'd0 || mask_r[0]) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_track_nxt = (mask_r == 32'd0) ? TRACK_NONE : {1'b0, idx_r[4:3]};
                out_step_nxt  = (mask_r == 32'd0) ? 3'd0 : idx_r[2:0];
                out_ptype_nxt = 3'd0;
                out_delta_nxt = DELTA_NONE;
                out_last_nxt  = 1'b1;
                state_nxt     = ST_IDLE;
              end
            end else begin
              mask_nxt = mask_r >> 1;
              idx_nxt  = idx_r + 1'b1;
            end
          end
          KIND_ADJUST: begin
            if (mask_r[0]) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_track_nxt = 3'd0;
                out_step_nxt  = 3'd0;
                out_ptype_nxt = {1'b0, idx_r[4:3]} + 3'd1;
                out_delta_nxt = idx_r[2] ? DELTA_UP : DELTA_DOWN;
                out_last_nxt  = 1'b1;
                state_nxt     = ST_IDLE;
              end
            end else begin
              mask_nxt = mask_r >> 1;
              idx_nxt  = idx_r + 1'b1;
            end
          end
          KIND_TOGGLE: begin
            if (mask_r[0]) begin
              if (out_free) begin
                out_valid_nxt = 1'b1;
                out_track_nxt = {1'b0, idx_r[4:3]};
                out_step_nxt  = idx_r[2:0];
                out_ptype_nxt = 3'd0;
                out_delta_nxt = DELTA_NONE;
                out_last_nxt  = (mask_r[31:1] == 31'd0);
                mask_nxt      = mask_r >> 1;
                idx_nxt       = idx_r + 1'b1;
                if (mask_r[31:1] == 31'd0) begin
                  state_nxt = ST_IDLE;
                end
              end
            end else begin
              mask_nxt = mask_r >> 1;
              idx_nxt  = idx_r + 1'b1;
            end
          end
          default: begin
            state_nxt = ST_IDLE;
          end
        endcase
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      thr_r       <= HOLD_THR_RESET;
      prev_btn_r  <= '0;
      prev_lock_r <= 1'b0;
      mode_r      <= KIND_EXIT;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      if (cfg_we) begin
        thr_r <= cfg_wdata;
      end
      prev_btn_r  <= prev_btn_nxt;
      prev_lock_r <= prev_lock_nxt;
      mode_r      <= mode_nxt;
      out_valid_r <= out_valid_nxt;
    end
    mask_r      <= mask_nxt;
    idx_r       <= idx_nxt;
    stamp_r     <= stamp_nxt;
    out_kind_r  <= out_kind_nxt;
    out_track_r <= out_track_nxt;
    out_step_r  <= out_step_nxt;
    out_ptype_r <= out_ptype_nxt;
    out_delta_r <= out_delta_nxt;
    out_stamp_r <= out_stamp_nxt;
    out_last_r  <= out_last_nxt;
  end

  a_toggle_mask_live: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN && mode_r == KIND_TOGGLE) |-> (mask_r != 32'd0))
    else $error("toggle scan running with an empty release mask");

  a_single_word_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_TOGGLE) |-> out_last_r)
    else $error("lock or adjust word not marked last");

  a_adjust_only_fields: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r != KIND_ADJUST) |->
      (out_delta_r == DELTA_NONE && out_ptype_r == 3'd0))
    else $error("adjust fields set on a non-adjust word");

  a_prev_tracks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (in_ch.valid && in_ch.ready) |=> (prev_btn_r == $past(in_ch.button_states)))
    else $error("stored mask does not follow the accepted snapshot");

endmodule
